@@ rtl/gsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator package
// Command and response beat types, command and status codes, slot pair type.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int IDX_W = 8;
    localparam int GEN_W = 32;

    localparam logic [1:0] CMD_CREATE  = 2'd0;
    localparam logic [1:0] CMD_DESTROY = 2'd1;
    localparam logic [1:0] CMD_CHECK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] handle_index;
        logic [GEN_W-1:0] handle_generation;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] out_index;
        logic [GEN_W-1:0] out_generation;
    } t_rsp;

    // Per-slot record: live generation (0 = dead) and generation for next use
    typedef struct packed {
        logic [GEN_W-1:0] live;
        logic [GEN_W-1:0] next;
    } t_gen_pair;

endpackage

@@ rtl/gsa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/generational_slot_allocator.sv @@
`timescale 1ns / 1ps
// A command accepted into the A-stage register moves on to the B-stage register and then
// to the response register, which raises the result strobe.
// Throughput: one command per cycle while busy is low; busy is set by reset.
// The receiver cannot stall: every result is shown for exactly one cycle.
// Reset (synchronous, active low): all slots dead and free, stack full; no clearing
// pass runs, so commands are taken once busy falls after reset is released.
// ----------------------------------------------------------------------------
// Generational slot allocator
// Pops and pushes slots on a LIFO free stack and validates index/generation
// handles against per-slot generation records held in RAM.
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
    parameter int SLOTS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  gsa_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output gsa_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(SLOTS);      // slot address width
    localparam int CW = $clog2(SLOTS + 1);  // stack count width (holds SLOTS)
    localparam int XW = AW + gsa_pkg::IDX_W;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);

    // ------------------------------------------------------------------------
    // Pipeline
    //   A stage: command register. Pops the free stack (the top entry comes
    //            from the stack RAM read issued at the previous edge, a push
    //            forwarded from B, or the untouched reset pattern) and issues
    //            the generation RAM read for the slot.
    //   B stage: generation record arrives; liveness check, destroy push,
    //            generation RAM write, response build.
    //   Output : response register, one-cycle strobe.
    //
    // Neither RAM is cleared. Stack entries at or above the lowest count ever
    // reached have been pushed since; entries below it still hold the reset
    // pattern (entry k = SLOTS-1-k). Slots are first handed out in order
    // 0, 1, 2, ..., so a slot below SLOTS minus that low mark has a written
    // record and any other slot reads as all-zero.
    // ------------------------------------------------------------------------

    logic w_accept;

    // control and stack state
    logic          r_busy;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_low, n_low;
    logic          r_stk_byp, n_stk_byp;
    logic [AW-1:0] r_stk_byp_val;

    // A stage
    logic          r_a_vld;
    gsa_pkg::t_req r_a_req;

    // B stage
    logic                      r_b_vld;
    logic [1:0]                r_b_cmd;
    logic [AW-1:0]             r_b_idx;
    logic                      r_b_idx_ok;
    logic [gsa_pkg::GEN_W-1:0] r_b_hgen;
    logic                      r_b_full;
    logic [AW-1:0]             r_b_slot;
    logic                      r_gvalid;
    logic                      r_gbyp, n_gbyp;
    gsa_pkg::t_gen_pair        r_gbyp_data;

    // output
    logic          r_valid;
    gsa_pkg::t_rsp r_rsp, n_rsp;

    // A stage signals
    logic [XW-1:0] a_idx_ext;
    logic [AW-1:0] a_idx;
    logic          a_idx_ok;
    logic          a_create;
    logic          a_empty;
    logic          a_pop;
    logic          a_fresh;
    logic [CW-1:0] a_fresh_w;
    logic [AW-1:0] a_slot;
    logic [AW-1:0] a_graddr;
    logic [CW-1:0] a_written;
    logic          a_gvalid;

    // B stage signals
    gsa_pkg::t_gen_pair        b_pair;
    logic                      b_hit;
    logic                      b_push;
    logic                      b_create_ok;
    logic [gsa_pkg::GEN_W-1:0] b_new_gen;
    logic [gsa_pkg::GEN_W-1:0] b_inc;
    logic [gsa_pkg::GEN_W-1:0] b_kill_gen;

    // RAM ports
    logic               g_we;
    logic [AW-1:0]      g_waddr;
    gsa_pkg::t_gen_pair g_wdata;
    gsa_pkg::t_gen_pair g_rdata;
    logic [CW-1:0]      s_rptr;
    logic [AW-1:0]      s_rdata;

    assign w_accept = start && !r_busy;

    // ------------------------------------------------------------------------
    // A stage: pop and slot select
    // ------------------------------------------------------------------------
    assign a_idx_ext = {{AW{1'b0}}, r_a_req.handle_index};
    assign a_idx     = a_idx_ext[AW-1:0];
    assign a_idx_ok  = a_idx_ext < SLOTS_X;

    assign a_create = r_a_vld && (r_a_req.cmd == gsa_pkg::CMD_CREATE);
    // The push retiring in B this cycle is ordered ahead of this pop
    assign a_empty  = (r_count == '0) && !b_push;
    assign a_pop    = a_create && !a_empty;

    // Top entry never popped yet: it still holds the reset pattern
    assign a_fresh   = (r_count == r_low);
    assign a_fresh_w = SLOTS_C - r_count;

    always_comb begin
        if (b_push) begin
            a_slot = r_b_idx;
        end else if (r_stk_byp) begin
            a_slot = r_stk_byp_val;
        end else if (a_fresh) begin
            a_slot = a_fresh_w[AW-1:0];
        end else begin
            a_slot = s_rdata;
        end
    end

    assign a_graddr = (r_a_req.cmd == gsa_pkg::CMD_CREATE) ? a_slot : a_idx;
    // Low mark before this cycle's pop: a slot popped fresh right now reads zero
    assign a_written = SLOTS_C - r_low;
    assign a_gvalid  = CW'(a_graddr) < a_written;

    // ------------------------------------------------------------------------
    // B stage: check, update, respond
    // ------------------------------------------------------------------------
    always_comb begin
        if (r_gbyp) begin
            b_pair = r_gbyp_data;
        end else if (r_gvalid) begin
            b_pair = g_rdata;
        end else begin
            b_pair = '0;
        end
    end

    assign b_hit = r_b_idx_ok && (r_b_hgen != '0) && (b_pair.live == r_b_hgen);

    assign b_push      = r_b_vld && (r_b_cmd == gsa_pkg::CMD_DESTROY) && b_hit
                         && (r_count < SLOTS_C);
    assign b_create_ok = r_b_vld && (r_b_cmd == gsa_pkg::CMD_CREATE) && !r_b_full;

    // Generation zero is reserved for the null handle: skip it
    assign b_new_gen  = (b_pair.next == '0) ? gsa_pkg::GEN_W'(1) : b_pair.next;
    assign b_inc      = b_pair.live + gsa_pkg::GEN_W'(1);
    assign b_kill_gen = (b_inc == '0) ? gsa_pkg::GEN_W'(1) : b_inc;

    assign g_we    = b_create_ok || b_push;
    assign g_waddr = b_create_ok ? r_b_slot : r_b_idx;

    always_comb begin
        if (b_create_ok) begin
            g_wdata.live = b_new_gen;
            g_wdata.next = b_pair.next;
        end else begin
            g_wdata.live = '0;
            g_wdata.next = b_kill_gen;
        end
    end

    always_comb begin
        n_rsp = '0;
        case (r_b_cmd)
            gsa_pkg::CMD_CREATE: begin
                if (r_b_full) begin
                    n_rsp.status = gsa_pkg::ST_FULL;
                end else begin
                    n_rsp.status         = gsa_pkg::ST_OK;
                    n_rsp.out_index      = gsa_pkg::IDX_W'(r_b_slot);
                    n_rsp.out_generation = b_new_gen;
                end
            end
            gsa_pkg::CMD_DESTROY: begin
                n_rsp.status = b_push ? gsa_pkg::ST_OK : gsa_pkg::ST_STALE;
            end
            gsa_pkg::CMD_CHECK: begin
                n_rsp.status = b_hit ? gsa_pkg::ST_OK : gsa_pkg::ST_STALE;
            end
            default: begin
                n_rsp.status = gsa_pkg::ST_STALE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Stack pointer, low mark and read-after-write bypasses
    // ------------------------------------------------------------------------
    assign n_count = r_count + CW'(b_push) - CW'(a_pop);
    assign n_low   = (n_count < r_low) ? n_count : r_low;
    assign s_rptr  = n_count - CW'(1);

    // Push landing on the entry being read at the same edge
    assign n_stk_byp = b_push && !a_pop;
    // Record write landing on the slot being read at the same edge
    assign n_gbyp    = g_we && (g_waddr == a_graddr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_count   <= SLOTS_C;
            r_low     <= SLOTS_C;
            r_stk_byp <= 1'b0;
            r_gbyp    <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_count   <= n_count;
            r_low     <= n_low;
            r_stk_byp <= n_stk_byp;
            r_gbyp    <= n_gbyp;
            r_a_vld   <= w_accept;
            r_b_vld   <= r_a_vld;
            r_valid   <= r_b_vld;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_req <= i_req;
        end
        r_stk_byp_val <= r_b_idx;
        r_gbyp_data   <= g_wdata;
        r_b_cmd       <= r_a_req.cmd;
        r_b_idx       <= a_idx;
        r_b_idx_ok    <= a_idx_ok;
        r_b_hgen      <= r_a_req.handle_generation;
        r_b_full      <= a_empty;
        r_b_slot      <= a_slot;
        r_gvalid      <= a_gvalid;
        r_rsp         <= n_rsp;
    end

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    gsa_ram #(
        .WIDTH ($bits(gsa_pkg::t_gen_pair)),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (a_graddr),
        .o_rdata (g_rdata)
    );

    gsa_ram #(
        .WIDTH (AW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (b_push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_b_idx),
        .i_raddr (s_rptr[AW-1:0]),
        .o_rdata (s_rdata)
    );

    assign busy    = r_busy;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

`ifndef SYNTH
    logic w_accept_q;
    assign w_accept_q = w_accept;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= SLOTS_C) && (r_low <= r_count))
        else $error("free stack count or low mark out of range");

    a_beat_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept_q |-> ##3 o_valid)
        else $error("accepted beat produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept_q, 3))
        else $error("result without an accepted beat");

    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_create_ok |-> (b_new_gen != '0))
        else $error("create handed out the null generation");

    a_no_push_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_pop |-> ((r_count != '0) || b_push))
        else $error("pop from an empty free stack");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational slot allocator testbench
// Drives create, destroy, check and reserved-code command beats with random
// idle gaps. A cycle-accurate shadow of the slot table and free stack works
// out each response at acceptance. The monitor compares every response strobe
// against the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS = 256;
    // Command code 3 is not assigned; the block must answer it as stale
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int RANDOM_BEATS = 1950;
    localparam int PHASE_LEN = 250;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 400000;

    // Traffic mix: churn is balanced, fill runs the stack dry, drain empties the table
    typedef enum int {
        MIX_CHURN,
        MIX_FILL,
        MIX_DRAIN
    } t_mix;

    typedef struct {
        gsa_pkg::t_req req;
        int unsigned   gap;
    } t_pending_cmd;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    gsa_pkg::t_req  i_req = '0;
    logic           busy;
    logic           o_valid;
    gsa_pkg::t_rsp  o_rsp;

    generational_slot_allocator #(
        .SLOTS (SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow of the allocator state
    // ------------------------------------------------------------------------
    logic [gsa_pkg::GEN_W-1:0] slot_live_gen [SLOTS];
    logic [gsa_pkg::GEN_W-1:0] slot_next_gen [SLOTS];
    logic [gsa_pkg::IDX_W-1:0] spare_slots   [SLOTS];
    int                        free_count;

    t_pending_cmd  pend_q[$];
    gsa_pkg::t_rsp rsp_expect_q[$];
    t_pending_cmd  staged_cmd;
    logic          staged = 1'b0;
    int            mismatches = 0;
    int unsigned   cycle_count = 0;

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            slot_live_gen[k] = '0;
            slot_next_gen[k] = '0;
            spare_slots[k]   = gsa_pkg::IDX_W'(SLOTS - 1 - k);
        end
        free_count = SLOTS;
    end

    // Apply one accepted command beat to the shadow and return its response.
    // The handle index is 8 bits wide, so it can never reach past the table.
    function automatic gsa_pkg::t_rsp slot_table_step(input gsa_pkg::t_req r);
        gsa_pkg::t_rsp             rsp;
        logic [gsa_pkg::IDX_W-1:0] slot;
        logic [gsa_pkg::GEN_W-1:0] gen_now;
        logic                      handle_live;
        rsp = '0;
        rsp.status = gsa_pkg::ST_STALE;
        handle_live = (r.handle_generation != '0) &&
                      (slot_live_gen[r.handle_index] == r.handle_generation);
        case (r.cmd)
            gsa_pkg::CMD_CREATE: begin
                if (free_count == 0) begin
                    rsp.status = gsa_pkg::ST_FULL;
                end else begin
                    free_count--;
                    slot = spare_slots[free_count];
                    gen_now = (slot_next_gen[slot] == '0) ? gsa_pkg::GEN_W'(1)
                                                          : slot_next_gen[slot];
                    slot_live_gen[slot] = gen_now;
                    rsp.status = gsa_pkg::ST_OK;
                    rsp.out_index = slot;
                    rsp.out_generation = gen_now;
                end
            end
            gsa_pkg::CMD_DESTROY: begin
                // A live handle implies a popped slot, so the stack has room
                if (handle_live && free_count < SLOTS) begin
                    gen_now = slot_live_gen[r.handle_index] + gsa_pkg::GEN_W'(1);
                    if (gen_now == '0) begin
                        gen_now = gsa_pkg::GEN_W'(1);
                    end
                    slot_live_gen[r.handle_index] = '0;
                    slot_next_gen[r.handle_index] = gen_now;
                    spare_slots[free_count] = r.handle_index;
                    free_count++;
                    rsp.status = gsa_pkg::ST_OK;
                end
            end
            gsa_pkg::CMD_CHECK: begin
                rsp.status = handle_live ? gsa_pkg::ST_OK : gsa_pkg::ST_STALE;
            end
            default: begin
                // Reserved code: stale, nothing touched
            end
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Idle gaps come in stretches: every other block of 64 beats runs back to back
    function automatic int unsigned draw_gap(input int n);
        if (((n / 64) % 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    task automatic push_cmd(input logic [1:0] cmd, input logic [gsa_pkg::IDX_W-1:0] idx,
                            input logic [gsa_pkg::GEN_W-1:0] gen, input int unsigned gap);
        t_pending_cmd p;
        p.req.cmd = cmd;
        p.req.handle_index = idx;
        p.req.handle_generation = gen;
        p.gap = gap;
        pend_q.push_back(p);
    endtask

    // Build one random command from the current shadow, mostly aimed at live
    // handles so destroy and check get past the stale path. The shadow may lag
    // by the one beat in flight, which only adds a few stale handles.
    function automatic gsa_pkg::t_req draw_command(input t_mix mix);
        gsa_pkg::t_req             r;
        int                        live_total;
        int                        pick;
        int                        roll;
        int                        create_pct;
        int                        destroy_pct;
        int                        check_pct;
        logic [gsa_pkg::IDX_W-1:0] live_idx;
        r.cmd = gsa_pkg::CMD_CREATE;
        r.handle_index = gsa_pkg::IDX_W'($urandom_range(0, SLOTS - 1));
        r.handle_generation = $urandom;
        live_total = 0;
        live_idx = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (slot_live_gen[k] != '0) begin
                live_total++;
            end
        end
        if (live_total > 0) begin
            pick = $urandom_range(0, live_total - 1);
            for (int k = 0; k < SLOTS; k++) begin
                if (slot_live_gen[k] != '0) begin
                    if (pick == 0) begin
                        live_idx = gsa_pkg::IDX_W'(k);
                    end
                    pick--;
                end
            end
        end
        case (mix)
            MIX_FILL: begin
                create_pct = 88; destroy_pct = 4; check_pct = 4;
            end
            MIX_DRAIN: begin
                create_pct = 6; destroy_pct = 70; check_pct = 12;
            end
            default: begin
                create_pct = 40; destroy_pct = 30; check_pct = 15;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < create_pct || (roll < create_pct + destroy_pct + check_pct &&
                                  live_total == 0)) begin
            // create ignores the handle fields; leave them random
            return r;
        end
        if (roll < create_pct + destroy_pct + check_pct) begin
            r.cmd = (roll < create_pct + destroy_pct) ? gsa_pkg::CMD_DESTROY
                                                      : gsa_pkg::CMD_CHECK;
            r.handle_index = live_idx;
            r.handle_generation = slot_live_gen[live_idx];
            return r;
        end
        // Noise: broken handles and the reserved code
        r.cmd = $urandom_range(0, 1) ? gsa_pkg::CMD_DESTROY : gsa_pkg::CMD_CHECK;
        case ($urandom_range(0, 3))
            0: begin
                // right slot, future generation
                r.handle_index = live_idx;
                r.handle_generation = slot_live_gen[live_idx]
                                      + gsa_pkg::GEN_W'($urandom_range(1, 3));
            end
            1: begin
                // null generation on a live slot
                r.handle_index = live_idx;
                r.handle_generation = '0;
            end
            2: begin
                // fully random handle, keep as drawn
            end
            default: begin
                r.cmd = CMD_RESERVED;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: stage the next pending command, sit out its gap, then hold start
    // until the beat is taken. Predict at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                rsp_expect_q.push_back(slot_table_step(i_req));
            end
            if (!(start && busy)) begin
                if (!staged && pend_q.size() != 0) begin
                    staged_cmd = pend_q.pop_front();
                    staged = 1'b1;
                end
                if (staged && staged_cmd.gap == 0) begin
                    start <= 1'b1;
                    i_req <= staged_cmd.req;
                    staged = 1'b0;
                end else begin
                    start <= 1'b0;
                    if (staged) begin
                        staged_cmd.gap--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every strobe retires the oldest expectation, field by field
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        gsa_pkg::t_rsp want;
        if (i_rst_n && o_valid) begin
            if (rsp_expect_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected response beat, expected none, actual %p",
                         $time, o_rsp);
            end else begin
                want = rsp_expect_q.pop_front();
                if (o_rsp.status !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_rsp.status);
                end
                if (o_rsp.out_index !== want.out_index) begin
                    mismatches++;
                    $display("%0t: out_index mismatch, expected %0d actual %0d",
                             $time, want.out_index, o_rsp.out_index);
                end
                if (o_rsp.out_generation !== want.out_generation) begin
                    mismatches++;
                    $display("%0t: out_generation mismatch, expected 0x%08h actual 0x%08h",
                             $time, want.out_generation, o_rsp.out_generation);
                end
            end
        end
    end

    // Watchdog: well above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: directed opening, then phased random traffic, then drain
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats; the table starts empty, so these outcomes are known.
        // The generation wrap past all ones is out of reach in a run this short.
        push_cmd(gsa_pkg::CMD_CHECK,   '0,   '0,    0); // null handle is stale
        push_cmd(gsa_pkg::CMD_CREATE,  '1,   '1,    0); // slot 0, gen 1
        push_cmd(gsa_pkg::CMD_CREATE,  '0,   '0,    0); // slot 1, gen 1
        push_cmd(gsa_pkg::CMD_CHECK,   8'd0, 32'd1, 0); // live
        push_cmd(gsa_pkg::CMD_CHECK,   8'd0, 32'd0, 0); // zero generation never live
        push_cmd(gsa_pkg::CMD_CHECK,   8'd0, 32'd2, 3); // future generation
        push_cmd(gsa_pkg::CMD_DESTROY, 8'd1, 32'd2, 0); // stale destroy, no change
        push_cmd(gsa_pkg::CMD_DESTROY, 8'd1, 32'd1, 0); // live destroy
        push_cmd(gsa_pkg::CMD_CHECK,   8'd1, 32'd1, 0); // now dead
        push_cmd(gsa_pkg::CMD_DESTROY, 8'd1, 32'd1, 0); // double destroy is stale
        push_cmd(gsa_pkg::CMD_CREATE,  '0,   '0,    5); // LIFO: slot 1 again, gen 2
        push_cmd(gsa_pkg::CMD_CHECK,   '1,   '1,    0); // top index, all-ones gen
        push_cmd(gsa_pkg::CMD_DESTROY, '1,   '1,    0);
        push_cmd(CMD_RESERVED,         '1,   '1,    0);
        push_cmd(CMD_RESERVED,         '0,   '0,    0);
        push_cmd(gsa_pkg::CMD_CREATE,  '0,   '0,    0); // slot 2, gen 1
        push_cmd(gsa_pkg::CMD_DESTROY, 8'd0, 32'd1, 0);
        push_cmd(gsa_pkg::CMD_CREATE,  '0,   '0,    0); // slot 0, gen 2
        push_cmd(gsa_pkg::CMD_CHECK,   8'd0, 32'd2, 0);
        push_cmd(gsa_pkg::CMD_DESTROY, 8'd2, 32'd0, 0);
        push_cmd(gsa_pkg::CMD_DESTROY, 8'd2, 32'd1, 0);

        // Random traffic; top up the queue one beat at a time so each draw
        // sees a nearly current table.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            t_mix         mix;
            t_pending_cmd p;
            while (pend_q.size() != 0) begin
                @(negedge i_clk);
            end
            case ((n / PHASE_LEN) % 4)
                1:       mix = MIX_FILL;
                2:       mix = MIX_DRAIN;
                default: mix = MIX_CHURN;
            endcase
            p.req = draw_command(mix);
            p.gap = draw_gap(n);
            pend_q.push_back(p);
            @(negedge i_clk);
        end

        // Hold until every beat is taken and every response has come back
        while (pend_q.size() != 0 || staged || start) begin
            @(negedge i_clk);
        end
        while (rsp_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gsa_pkg.sv
rtl/gsa_ram.sv
rtl/generational_slot_allocator.sv
dv/testbench.sv
